// ----- hdl/pef_pkg.sv -----
package pef_pkg;

  // Port widths of the two channels.
  localparam int SAMPLE_W  = 16;
  localparam int DECADES_W = 12;
  localparam int LEVEL_W   = 32;

  // Number formats.
  localparam int SAMPLE_BITS      = 16;
  localparam int COEF_FRAC_BITS   = 24;
  localparam int DECADE_FRAC_BITS = 8;
  localparam int INT_W            = DECADES_W - DECADE_FRAC_BITS;
  localparam int FRAC_ENTRIES     = 2 ** DECADE_FRAC_BITS;
  localparam int INT_ENTRIES      = 2 ** INT_W;

  // Magnitude is Q16.16 no larger than 1.0, so it needs 17 bits.
  localparam int MAG_W   = 17;
  localparam int MAG_SHL = (SAMPLE_BITS < MAG_W) ? MAG_W - SAMPLE_BITS : 0;
  localparam int MAG_SHR = (SAMPLE_BITS > MAG_W) ? SAMPLE_BITS - MAG_W : 0;

  // The coefficient never exceeds 1.0.
  localparam int COEF_W = COEF_FRAC_BITS + 1;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [63:0] Q60_ONE = 64'd1 << 60;

  typedef logic [FRAC_ENTRIES-1:0][COEF_W-1:0] frac_tab_t;
  typedef logic [INT_ENTRIES-1:0][COEF_W-1:0]  int_tab_t;

  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic [COEF_W-1:0] coef;
  } pef_item_t;

  // The functions below run only at elaboration to build the coefficient tables.

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int s);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod >> s;
    return prod[63:0];
  endfunction

  // atanh(1/q) in Q60.
  function automatic logic [63:0] atanh_inv(input logic [63:0] q);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] qq;
    p   = udiv64(Q60_ONE, q);
    sum = '0;
    qq  = q * q;
    for (int k = 0; k < 64; k++) begin
      if (p != '0) begin
        sum = sum + udiv64(p, 64'(2 * k + 1));
        p   = udiv64(p, qq);
      end
    end
    return sum;
  endfunction

  // Ten to the minus f / 2^DECADE_FRAC_BITS, rounded to COEF_FRAC_BITS fraction bits.
  function automatic logic [63:0] frac_coef(input logic [63:0] f, input logic [63:0] ln10);
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] sum;
    logic [63:0] term;
    t    = mul_shr(ln10, f, DECADE_FRAC_BITS);
    u    = t >> 2;
    sum  = Q60_ONE;
    term = Q60_ONE;
    for (int k = 1; k <= 40; k++) begin
      term = udiv64(mul_shr(term, u, 60), 64'(k));
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    sum = mul_shr(sum, sum, 60);
    sum = mul_shr(sum, sum, 60);
    return (sum + (64'd1 << (59 - COEF_FRAC_BITS))) >> (60 - COEF_FRAC_BITS);
  endfunction

  // Ten to the minus n, rounded to COEF_FRAC_BITS fraction bits.
  function automatic logic [63:0] int_coef(input int n);
    logic [63:0] p;
    p = 64'd1;
    if (n > 19) begin
      return '0;
    end
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return udiv64((64'd1 << COEF_FRAC_BITS) + (p >> 1), p);
  endfunction

  function automatic frac_tab_t build_frac_tab();
    frac_tab_t   tab;
    logic [63:0] ln10;
    ln10 = 64'd6 * atanh_inv(64'd3) + 64'd2 * atanh_inv(64'd9);
    for (int f = 0; f < FRAC_ENTRIES; f++) begin
      tab[f] = COEF_W'(frac_coef(64'(f), ln10));
    end
    return tab;
  endfunction

  function automatic int_tab_t build_int_tab();
    int_tab_t tab;
    for (int n = 0; n < INT_ENTRIES; n++) begin
      tab[n] = COEF_W'(int_coef(n));
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac_tab();
  localparam int_tab_t  INT_TAB  = build_int_tab();

endpackage

// ----- hdl/pef_front.sv -----
module pef_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pef_pkg::SAMPLE_W-1:0]      in_sample,
  input  logic [pef_pkg::DECADES_W-1:0]     in_decades,
  output logic                              push_valid,
  input  logic                              push_ready,
  output pef_pkg::pef_item_t                push_item
);
  import pef_pkg::*;

  logic                        stg_v_r, stg_v_nxt;
  logic [MAG_W-1:0]            mag_r;
  logic [COEF_W-1:0]           tf_r;
  logic [COEF_W-1:0]           ti_r;
  logic [SAMPLE_BITS-1:0]      raw;
  logic [SAMPLE_BITS-1:0]      raw_abs;
  logic [MAG_W-1:0]            mag_q;
  logic [DECADE_FRAC_BITS-1:0] frac_idx;
  logic [INT_W-1:0]            int_idx;
  logic [2*COEF_W-1:0]         coef_prod;
  logic                        in_fire;
  logic                        push_fire;

  // Magnitude of the two's complement sample; the most negative code maps to full scale.
  assign raw     = in_sample[SAMPLE_BITS-1:0];
  assign raw_abs = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
  assign mag_q   = MAG_W'(((MAG_W + SAMPLE_BITS)'(raw_abs) << MAG_SHL) >> MAG_SHR);

  assign int_idx  = in_decades[DECADES_W-1:DECADE_FRAC_BITS];
  assign frac_idx = in_decades[DECADE_FRAC_BITS-1:0];

  assign in_ready  = !stg_v_r || push_ready;
  assign in_fire   = in_valid && in_ready;
  assign push_fire = stg_v_r && push_ready;

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (in_fire) begin
      stg_v_nxt = 1'b1;
    end else if (push_fire) begin
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mag_r <= mag_q;
      tf_r  <= FRAC_TAB[frac_idx];
      ti_r  <= INT_TAB[int_idx];
    end
  end

  // Combine the fractional and integer decade factors into one coefficient.
  assign coef_prod      = (2 * COEF_W)'(tf_r) * (2 * COEF_W)'(ti_r);
  assign push_valid     = stg_v_r;
  assign push_item.mag  = mag_r;
  assign push_item.coef = COEF_W'(coef_prod >> COEF_FRAC_BITS);

endmodule

// ----- hdl/pef_queue.sv -----
module pef_queue #(
  parameter int DEPTH = pef_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  pef_pkg::pef_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output pef_pkg::pef_item_t pop_item
);
  import pef_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pef_item_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on a push");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_fire && !push_fire) |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count did not shrink on a pop");

  a_empty_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && count_r == '0) |=> pop_valid && pop_item == $past(push_item))
    else $error("item pushed into an empty queue is not at its head");

endmodule

// ----- hdl/pef_back.sv -----
module pef_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  pef_pkg::pef_item_t           pop_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pef_pkg::LEVEL_W-1:0]  out_level
);
  import pef_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD   = 2'b01,
    ST_UPDATE = 2'b10
  } back_state_t;

  back_state_t               state_r, state_nxt;
  logic [LEVEL_W-1:0]        level_r, level_nxt;
  logic                      rise_r;
  logic [MAG_W-1:0]          gain_r;
  logic [LEVEL_W-1:0]        loss_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]        out_level_r;
  logic [MAG_W+COEF_W-1:0]   gain_prod;
  logic [LEVEL_W+COEF_W-1:0] loss_prod;
  logic [LEVEL_W:0]          rise_sum;
  logic                      pop_fire;
  logic                      upd_fire;

  assign pop_ready = (state_r == ST_LOAD);
  assign pop_fire  = pop_valid && pop_ready;
  assign upd_fire  = (state_r == ST_UPDATE) && (!out_valid_r || out_ready);

  // Both candidate steps are formed while the item is taken; the compare picks one later.
  assign gain_prod = (MAG_W + COEF_W)'(pop_item.mag) * (MAG_W + COEF_W)'(pop_item.coef);
  assign loss_prod = (LEVEL_W + COEF_W)'(level_r) * (LEVEL_W + COEF_W)'(pop_item.coef);

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      rise_r <= (LEVEL_W'(pop_item.mag) >= level_r);
      gain_r <= MAG_W'(gain_prod >> COEF_FRAC_BITS);
      loss_r <= LEVEL_W'(loss_prod >> COEF_FRAC_BITS);
    end
  end

  assign rise_sum = (LEVEL_W + 1)'(level_r) + (LEVEL_W + 1)'(gain_r);

  always_comb begin
    if (rise_r) begin
      level_nxt = rise_sum[LEVEL_W] ? '1 : rise_sum[LEVEL_W-1:0];
    end else begin
      level_nxt = level_r - loss_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (pop_fire) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_fire) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (upd_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (upd_fire) begin
        level_r <= level_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_level_r <= level_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

  a_load_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    pop_fire |=> state_r == ST_UPDATE)
    else $error("taken item did not move on to the update step");

  a_rise_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_fire && rise_r) |-> level_nxt >= level_r)
    else $error("level fell on the rising branch");

  a_fall_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_fire && !rise_r) |-> level_nxt <= level_r)
    else $error("level grew on the falling branch");

  a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
    upd_fire |=> out_valid_r && out_level_r == level_r)
    else $error("presented result differs from the stored level");

endmodule

// ----- hdl/peak_envelope_follower_unit.sv -----
// Peak envelope follower. Each input transaction carries a signed audio sample and a
// falloff in decades (unsigned Q4.8); each one yields exactly one output transaction
// with the followed level in unsigned Q16.16, saturated at all ones.
// Both channels use valid/ready; a transaction completes when both are high.
// A result passes through the front-end register, the queue, the back end's item
// registers and the output register. The back end takes no new item until the last
// one's level is updated: the level feedback loop (take item, then update level).
// The front end registers the magnitude and table lookups and forms the coefficient
// with one multiplier; a small queue (QUEUE_DEPTH entries) decouples it from the back.
// Reset (rst_n low, synchronous) clears the level to zero and empties the pipeline;
// no result is pending afterwards. When the receiver holds out_ready low, the result
// waits in the output register, the back end holds its next update, the queue fills,
// and only then does in_ready drop; nothing is lost or repeated.
module peak_envelope_follower_unit #(
  parameter int QUEUE_DEPTH = pef_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pef_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic [pef_pkg::DECADES_W-1:0]   in_decades,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pef_pkg::LEVEL_W-1:0]     out_level
);
  import pef_pkg::*;

  // Front end to queue.
  logic      push_valid;
  logic      push_ready;
  pef_item_t push_item;

  // Queue to back end.
  logic      pop_valid;
  logic      pop_ready;
  pef_item_t pop_item;

  // The front end forms the magnitude and the decay coefficient for each sample.
  pef_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .in_decades (in_decades),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // The queue lets the front end keep accepting while the back end is busy.
  pef_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // The back end owns the level register and the output register.
  pef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_level (out_level)
  );

endmodule

// ----- sim/peak_envelope_follower_checker.sv -----
module peak_envelope_follower_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [pef_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [pef_pkg::DECADES_W-1:0] in_decades,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [pef_pkg::LEVEL_W-1:0]   out_level,
  output int                            errors,
  output int                            pending,
  output int                            checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import pef_pkg::*;

  localparam real LN_TEN = 2.302585092994045684;

  // Ten to the minus fraction, and ten to the minus whole decades, in Q1.COEF_FRAC_BITS.
  logic [COEF_W-1:0]  frac_falloff [FRAC_ENTRIES];
  logic [COEF_W-1:0]  whole_falloff [INT_ENTRIES];
  logic [LEVEL_W-1:0] envelope_now;
  logic [LEVEL_W-1:0] levels_due [$];
  int                 fail_count;
  int                 match_count;

  // e^x by its power series; x stays below 2.3, so sixty terms are far more than enough.
  function automatic real exp_series(input real x);
    real sum;
    real term;
    sum  = 1.0;
    term = 1.0;
    for (int k = 1; k < 60; k++) begin
      term = term * x / k;
      sum  = sum + term;
    end
    return sum;
  endfunction

  // Next envelope value for one sample and falloff, starting from lvl.
  function automatic logic [LEVEL_W-1:0] follow_peak(input logic [LEVEL_W-1:0]   lvl,
                                                     input logic [SAMPLE_W-1:0]  s,
                                                     input logic [DECADES_W-1:0] d);
    logic [63:0] mag;
    logic [63:0] coef;
    logic [63:0] nxt;
    mag  = s[SAMPLE_W-1] ? (64'd1 << SAMPLE_W) - 64'(s) : 64'(s);
    mag  = mag << (17 - SAMPLE_BITS);
    coef = (64'(frac_falloff[d[DECADE_FRAC_BITS-1:0]]) *
            64'(whole_falloff[d[DECADES_W-1:DECADE_FRAC_BITS]])) >> COEF_FRAC_BITS;
    if (mag >= 64'(lvl)) begin
      nxt = 64'(lvl) + ((mag * coef) >> COEF_FRAC_BITS);
      if (nxt > 64'hFFFF_FFFF) begin
        nxt = 64'hFFFF_FFFF;
      end
    end else begin
      nxt = 64'(lvl) - ((64'(lvl) * coef) >> COEF_FRAC_BITS);
    end
    return nxt[LEVEL_W-1:0];
  endfunction

  initial begin
    logic [63:0] pow_ten;
    pow_ten = 64'd1;
    for (int f = 0; f < FRAC_ENTRIES; f++) begin
      frac_falloff[f] = COEF_W'($rtoi(real'(64'd1 << COEF_FRAC_BITS) /
                                      exp_series(LN_TEN * f / FRAC_ENTRIES) + 0.5));
    end
    for (int n = 0; n < INT_ENTRIES; n++) begin
      whole_falloff[n] = COEF_W'(((64'd1 << COEF_FRAC_BITS) + pow_ten / 2) / pow_ten);
      pow_ten = pow_ten * 64'd10;
    end
    fail_count  = 0;
    match_count = 0;
  end

  // Results are retired before new samples are predicted, so a result that shows up
  // with nothing outstanding is flagged even when a sample lands in the same cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      envelope_now = '0;
      levels_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (levels_due.size() == 0) begin
          $error("level: unexpected transaction, actual %0d", out_level);
          fail_count++;
        end else begin
          if (out_level !== levels_due[0]) begin
            $error("level mismatch: expected %0d, actual %0d", levels_due[0], out_level);
            fail_count++;
          end else begin
            match_count++;
          end
          void'(levels_due.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        envelope_now = follow_peak(envelope_now, in_sample, in_decades);
        levels_due.push_back(envelope_now);
      end
    end
    errors  <= fail_count;
    pending <= levels_due.size();
    checked <= match_count;
  end

endmodule

// ----- sim/peak_envelope_follower_unit_tb.sv -----
module peak_envelope_follower_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pef_pkg::*;

  // Stimulus stops after the segment in which this many samples have gone in; the watchdog bounds the run.
  localparam int TARGET_SAMPLES = 1100;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int TAIL_CYCLES    = 8;

  // Kinds of signal segment in the random part.
  typedef enum int {TONE, BURST, NOISE, QUIET, RAIL} segment_kind_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  in_sample  = '0;
  logic [DECADES_W-1:0] in_decades = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [LEVEL_W-1:0]   out_level;

  int errors;
  int pending;
  int checked;
  int sent        = 0;
  int cycle_count = 0;
  int drains      = 0;

  // When set, that side of the handshake never idles, so back-to-back traffic is seen.
  bit calm_in  = 1'b0;
  bit calm_out = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  peak_envelope_follower_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .in_decades (in_decades),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_level  (out_level)
  );

  // The checker keeps its own copy of the envelope and compares every result.
  peak_envelope_follower_checker level_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .in_decades (in_decades),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_level  (out_level),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  function automatic int idle_cycles(input bit calm);
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // Falloff choice for a segment. Most of the weight sits in the first few decades,
  // where the envelope visibly moves; the rest covers zero falloff, the range where
  // the coefficient underflows to zero, and any code at all.
  function automatic logic [DECADES_W-1:0] pick_falloff();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return {INT_W'($urandom_range(0, 2)), DECADE_FRAC_BITS'($urandom)};
    end else if (r < 7) begin
      return {INT_W'($urandom_range(3, 7)), DECADE_FRAC_BITS'($urandom)};
    end else if (r == 7) begin
      return '0;
    end else if (r == 8) begin
      return {INT_W'($urandom_range(8, 15)), DECADE_FRAC_BITS'($urandom)};
    end
    return DECADES_W'($urandom);
  endfunction

  // Offers one sample transaction after a random gap and returns at the clock edge
  // where it was taken. Valid is only lowered when a gap is drawn, so a valid that
  // stays high between transactions never sees two assignments in one step.
  task automatic send(input logic [SAMPLE_W-1:0] s, input logic [DECADES_W-1:0] d);
    int gap;
    gap = idle_cycles(calm_in);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_sample  <= s;
    in_decades <= d;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Holds the sender off until every predicted level has come back. The first edge
  // is always waited for, since the checker's pending count is registered.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    drains++;
  endtask

  // Receiver: before each result it draws a stall, then waits with ready high until
  // the result has been taken.
  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = idle_cycles(calm_out);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog. A hang or a lost result ends up here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    segment_kind_t        kind;
    logic [DECADES_W-1:0] seg_falloff;
    logic [DECADES_W-1:0] d;
    int                   seg_len;
    int                   amp;
    int                   v;
    int                   segments;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Zero falloff with a held full-scale input: the level first takes
    // the magnitude, then doubles, then with a coefficient of one collapses to zero.
    send(16'h0000, 12'h000);
    send(16'h7FFF, 12'h000);
    send(16'h7FFF, 12'h000);
    send(16'h7FFF, 12'h000);
    // The most negative sample is exactly full scale; then a rise at one tenth.
    send(16'h8000, 12'h000);
    send(16'h8000, 12'h100);
    // Decay with fractional falloff, including the largest fraction.
    send(16'h0000, 12'h080);
    send(16'h0000, 12'h0FF);
    // Falloffs of eight decades and more underflow the coefficient and the level holds;
    // at seven decades the coefficient is only two LSBs.
    send(16'h0000, 12'hFFF);
    send(16'h0001, 12'h800);
    send(16'hFFFF, 12'h700);
    // Alternating bit patterns on both fields.
    send(16'h5555, 12'hAAA);
    send(16'hAAAA, 12'h555);
    send(16'h8001, 12'h001);
    send(16'h7FFF, 12'h0FF);
    send(16'h0000, 12'h300);
    send(16'h0000, 12'h200);
    // Repeated full-scale negative input at zero falloff.
    send(16'h8000, 12'h000);
    send(16'h8000, 12'h000);
    send(16'h8000, 12'h000);
    send(16'h0000, 12'hF00);
    send(16'h4000, 12'h000);
    drain();

    // Random part: segments that each look like a piece of signal with its own falloff,
    // so attacks, holds and long decays all develop. Each segment also picks whether
    // either side idles, which moves the gaps across every phase of the pipeline.
    segments = 0;
    while (sent < TARGET_SAMPLES) begin
      seg_len     = $urandom_range(4, 40);
      seg_falloff = pick_falloff();
      kind        = segment_kind_t'($urandom_range(0, 4));
      amp         = $urandom_range(0, 32767);
      calm_in     = ($urandom_range(0, 3) == 0);
      calm_out    = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg_len; i++) begin
        d = ($urandom_range(0, 7) == 0) ? DECADES_W'($urandom) : seg_falloff;
        case (kind)
          TONE: begin
            // A held amplitude with some ripple and alternating polarity.
            v = amp - int'($urandom_range(0, amp / 8));
            if (i % 2 == 1) begin
              v = -v;
            end
          end
          BURST: begin
            v = int'($urandom_range(0, 65535)) - 32768;
          end
          NOISE: begin
            v = int'($urandom_range(0, 511)) - 256;
          end
          QUIET: begin
            v = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3)) : 0;
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       v = 32767;
              1:       v = -32768;
              2:       v = -32767;
              default: v = 0;
            endcase
          end
        endcase
        send(SAMPLE_W'(v), d);
      end
      segments++;
      if (segments % 30 == 0) begin
        drain();
      end
    end

    // Let every outstanding level return, then a few more cycles for anything stray.
    calm_out = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d samples in %0d signal segments with %0d full drains; %0d levels matched.",
             sent, segments, drains, checked);
    $display("Covered zero falloff, coefficient underflow, full-scale negative input and decay.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/pef_pkg.sv
hdl/pef_front.sv
hdl/pef_queue.sv
hdl/pef_back.sv
hdl/peak_envelope_follower_unit.sv
sim/peak_envelope_follower_checker.sv
sim/peak_envelope_follower_unit_tb.sv
